>>> rtl/pfme_pkg.sv
`default_nettype none

package pfme_pkg;

    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_PAYLOAD_BITS = 64;

    localparam int SRC_W  = 8;
    localparam int SEQ_W  = 32;
    localparam int DIR_W  = 2;
    localparam int OWN_W  = 2;
    localparam int KEY_W  = SRC_W + SEQ_W;
    localparam int TAG_W  = DIR_W + OWN_W;
    localparam int HDR_W  = KEY_W + TAG_W;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_SEARCH  = 2'd2,
        MODE_EXTRACT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_NONE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic match_en;
        logic by_key;
        logic load_en;
        logic shift_all;
        logic extract_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pfme_cell.sv
`default_nettype none

module pfme_cell #(
    parameter int PAYLOAD_BITS = pfme_pkg::DEF_PAYLOAD_BITS
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire pfme_pkg::cell_ctrl_t       ctrl,
    input  wire [pfme_pkg::KEY_W-1:0]       req_key,
    input  wire [pfme_pkg::TAG_W-1:0]       req_tag,
    input  wire [PAYLOAD_BITS-1:0]          req_payload,
    input  wire                             prev_valid,
    input  wire                             nxt_valid,
    input  wire [pfme_pkg::KEY_W-1:0]       nxt_key,
    input  wire [pfme_pkg::TAG_W-1:0]       nxt_tag,
    input  wire [PAYLOAD_BITS-1:0]          nxt_payload,
    input  wire                             found_in,
    input  wire [pfme_pkg::KEY_W-1:0]       chain_key_in,
    input  wire [pfme_pkg::TAG_W-1:0]       chain_tag_in,
    input  wire [PAYLOAD_BITS-1:0]          chain_payload_in,
    output logic                            valid_o,
    output logic [pfme_pkg::KEY_W-1:0]      key_o,
    output logic [pfme_pkg::TAG_W-1:0]      tag_o,
    output logic [PAYLOAD_BITS-1:0]         payload_o,
    output logic                            found_out,
    output logic [pfme_pkg::KEY_W-1:0]      chain_key_out,
    output logic [pfme_pkg::TAG_W-1:0]      chain_tag_out,
    output logic [PAYLOAD_BITS-1:0]         chain_payload_out
);

    logic                       valid_reg;
    logic                       hit_reg;
    logic                       hit_next;
    logic [pfme_pkg::KEY_W-1:0] key_reg;
    logic [pfme_pkg::TAG_W-1:0] tag_reg;
    logic [PAYLOAD_BITS-1:0]    payload_reg;
    logic                       shift_en;
    logic                       load_en;

    assign hit_next = valid_reg & (ctrl.by_key ? (key_reg == req_key) : (tag_reg == req_tag));

    assign found_out = found_in | hit_reg;
    assign shift_en  = ctrl.shift_all | (ctrl.extract_en & found_out);
    assign load_en   = ctrl.load_en & prev_valid & ~valid_reg;

    // first hit wins; later cells pass the upstream word along
    always_comb begin
        priority if (found_in) begin
            chain_key_out     = chain_key_in;
            chain_tag_out     = chain_tag_in;
            chain_payload_out = chain_payload_in;
        end else if (hit_reg) begin
            chain_key_out     = key_reg;
            chain_tag_out     = tag_reg;
            chain_payload_out = payload_reg;
        end else begin
            chain_key_out     = '0;
            chain_tag_out     = '0;
            chain_payload_out = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            if (ctrl.match_en) begin
                hit_reg <= hit_next;
            end
            if (shift_en) begin
                valid_reg <= nxt_valid;
            end else if (load_en) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            key_reg     <= nxt_key;
            tag_reg     <= nxt_tag;
            payload_reg <= nxt_payload;
        end else if (load_en) begin
            key_reg     <= req_key;
            tag_reg     <= req_tag;
            payload_reg <= req_payload;
        end
    end

    assign valid_o   = valid_reg;
    assign key_o     = key_reg;
    assign tag_o     = tag_reg;
    assign payload_o = payload_reg;

endmodule

`default_nettype wire

>>> rtl/packet_fifo_with_match_and_extract_unit.sv
// Packet queue with associative search and in-order extraction.
// Input words arrive on s_tvalid/s_tready/s_tdata with the operation in
// s_tuser (write, read oldest, search by source and sequence, extract by
// direction and owner). Every input word yields exactly one result word on
// m_tvalid/m_tready/m_tdata, with the status code in m_tuser and the
// packet, occupancy, full and empty flags in m_tdata.
// Entries sit in a row of cells, oldest in cell 0. A word is accepted,
// then in the match state every cell compares its entry with the key
// (search) or the tag (other modes), and in the exec state the row
// shifts, loads or stays and the result is registered.
// The first-hit and returned-packet signals ripple down the cell row.
// The next word is taken in the same cycle as the result is registered.
// Reset (aresetn low, synchronous) empties the queue and drops any result.
// While m_tready is low a pending result holds; the next word finishes its
// compare and then waits, with s_tready low, until the output register
// frees up.
`default_nettype none

module packet_fifo_with_match_and_extract_unit #(
    parameter int QUEUE_DEPTH  = pfme_pkg::DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_BITS = pfme_pkg::DEF_PAYLOAD_BITS,
    localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W   = ((pfme_pkg::HDR_W + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((pfme_pkg::HDR_W + PAYLOAD_BITS + OCC_W + 2 + 7) / 8) * 8
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    // in_source_addr, in_sequence, in_direction, in_owner, in_payload
    input  wire [IN_W-1:0]   s_tdata,
    // mode
    input  wire [1:0]        s_tuser,
    output logic             m_tvalid,
    input  wire              m_tready,
    // out_source_addr, out_sequence, out_direction, out_owner, out_payload,
    // occupancy, full_flag, empty_flag
    output logic [OUT_W-1:0] m_tdata,
    // status
    output logic [1:0]       m_tuser
);

    localparam int KW  = pfme_pkg::KEY_W;
    localparam int TW  = pfme_pkg::TAG_W;
    localparam int SW  = pfme_pkg::SRC_W;
    localparam int QW  = pfme_pkg::SEQ_W;
    localparam int DW  = pfme_pkg::DIR_W;
    localparam int OW  = pfme_pkg::OWN_W;
    localparam int P_SEQ = SW;
    localparam int P_DIR = SW + QW;
    localparam int P_OWN = P_DIR + DW;
    localparam int P_PAY = P_OWN + OW;
    localparam int P_OCC = P_PAY + PAYLOAD_BITS;
    localparam int P_FUL = P_OCC + OCC_W;
    localparam int P_EMP = P_FUL + 1;

    pfme_pkg::state_t     state_reg, state_next;
    pfme_pkg::mode_t      mode_reg;
    pfme_pkg::cell_ctrl_t ctrl;

    logic [KW-1:0]           req_key_reg;
    logic [TW-1:0]           req_tag_reg;
    logic [PAYLOAD_BITS-1:0] req_payload_reg;
    logic [OCC_W-1:0]        fill_reg, fill_next;
    logic                    out_valid_reg;
    pfme_pkg::status_t       status_reg, status_next;
    logic [KW-1:0]           res_key_reg, res_key_next;
    logic [TW-1:0]           res_tag_reg, res_tag_next;
    logic [PAYLOAD_BITS-1:0] res_payload_reg, res_payload_next;

    logic out_free;
    logic accept;
    logic exec;
    logic is_full;
    logic is_empty;
    logic next_full;
    logic next_empty;

    logic [QUEUE_DEPTH-1:0]  valid_c;
    logic [KW-1:0]           key_c     [QUEUE_DEPTH];
    logic [TW-1:0]           tag_c     [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0] payload_c [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]    found_c;
    logic [KW-1:0]           ckey_c    [QUEUE_DEPTH+1];
    logic [TW-1:0]           ctag_c    [QUEUE_DEPTH+1];
    logic [PAYLOAD_BITS-1:0] cpay_c    [QUEUE_DEPTH+1];

    assign out_free = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign exec     = (state_reg == pfme_pkg::ST_EXEC) & out_free;
    assign is_full  = (fill_reg == OCC_W'(QUEUE_DEPTH));
    assign is_empty = (fill_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pfme_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            pfme_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = pfme_pkg::ST_MATCH;
                end
            end
            pfme_pkg::ST_MATCH: begin
                state_next = pfme_pkg::ST_EXEC;
            end
            pfme_pkg::ST_EXEC: begin
                s_tready = out_free;
                if (out_free) begin
                    state_next = s_tvalid ? pfme_pkg::ST_MATCH : pfme_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfme_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg        <= pfme_pkg::mode_t'(s_tuser);
            req_key_reg     <= {s_tdata[SW-1:0], s_tdata[P_SEQ +: QW]};
            req_tag_reg     <= {s_tdata[P_DIR +: DW], s_tdata[P_OWN +: OW]};
            req_payload_reg <= s_tdata[P_PAY +: PAYLOAD_BITS];
        end
    end

    always_comb begin
        ctrl.match_en   = (state_reg == pfme_pkg::ST_MATCH);
        ctrl.by_key     = (mode_reg == pfme_pkg::MODE_SEARCH);
        ctrl.load_en    = exec & (mode_reg == pfme_pkg::MODE_WRITE);
        ctrl.shift_all  = exec & (mode_reg == pfme_pkg::MODE_READ) & ~is_empty;
        ctrl.extract_en = exec & (mode_reg == pfme_pkg::MODE_EXTRACT);
    end

    assign found_c[0] = 1'b0;
    assign ckey_c[0]  = '0;
    assign ctag_c[0]  = '0;
    assign cpay_c[0]  = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic                    prev_v;
        logic                    nxt_v;
        logic [KW-1:0]           nxt_k;
        logic [TW-1:0]           nxt_t;
        logic [PAYLOAD_BITS-1:0] nxt_p;

        if (i == 0) begin : g_first
            assign prev_v = 1'b1;
        end else begin : g_mid
            assign prev_v = valid_c[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nxt_v = 1'b0;
            assign nxt_k = '0;
            assign nxt_t = '0;
            assign nxt_p = '0;
        end else begin : g_inner
            assign nxt_v = valid_c[i+1];
            assign nxt_k = key_c[i+1];
            assign nxt_t = tag_c[i+1];
            assign nxt_p = payload_c[i+1];
        end

        pfme_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .aclk              (aclk),
            .aresetn           (aresetn),
            .ctrl              (ctrl),
            .req_key           (req_key_reg),
            .req_tag           (req_tag_reg),
            .req_payload       (req_payload_reg),
            .prev_valid        (prev_v),
            .nxt_valid         (nxt_v),
            .nxt_key           (nxt_k),
            .nxt_tag           (nxt_t),
            .nxt_payload       (nxt_p),
            .found_in          (found_c[i]),
            .chain_key_in      (ckey_c[i]),
            .chain_tag_in      (ctag_c[i]),
            .chain_payload_in  (cpay_c[i]),
            .valid_o           (valid_c[i]),
            .key_o             (key_c[i]),
            .tag_o             (tag_c[i]),
            .payload_o         (payload_c[i]),
            .found_out         (found_c[i+1]),
            .chain_key_out     (ckey_c[i+1]),
            .chain_tag_out     (ctag_c[i+1]),
            .chain_payload_out (cpay_c[i+1])
        );
    end

    always_comb begin
        fill_next        = fill_reg;
        status_next      = pfme_pkg::STAT_OK;
        res_key_next     = '0;
        res_tag_next     = '0;
        res_payload_next = '0;
        unique case (mode_reg)
            pfme_pkg::MODE_WRITE: begin
                if (is_full) begin
                    status_next = pfme_pkg::STAT_FULL;
                end else begin
                    fill_next = fill_reg + OCC_W'(1);
                end
            end
            pfme_pkg::MODE_READ: begin
                if (is_empty) begin
                    status_next = pfme_pkg::STAT_EMPTY;
                end else begin
                    fill_next        = fill_reg - OCC_W'(1);
                    res_key_next     = key_c[0];
                    res_tag_next     = tag_c[0];
                    res_payload_next = payload_c[0];
                end
            end
            pfme_pkg::MODE_SEARCH: begin
                if (!found_c[QUEUE_DEPTH]) begin
                    status_next = pfme_pkg::STAT_NONE;
                end
            end
            pfme_pkg::MODE_EXTRACT: begin
                if (found_c[QUEUE_DEPTH]) begin
                    fill_next        = fill_reg - OCC_W'(1);
                    res_key_next     = ckey_c[QUEUE_DEPTH];
                    res_tag_next     = ctag_c[QUEUE_DEPTH];
                    res_payload_next = cpay_c[QUEUE_DEPTH];
                end else begin
                    status_next = pfme_pkg::STAT_NONE;
                end
            end
            default: begin
                status_next = pfme_pkg::STAT_NONE;
            end
        endcase
    end

    assign next_full  = (fill_next == OCC_W'(QUEUE_DEPTH));
    assign next_empty = (fill_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            priority if (exec) begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [OCC_W-1:0] occ_reg;
    logic             full_reg;
    logic             empty_reg;

    always_ff @(posedge aclk) begin
        if (exec) begin
            status_reg      <= status_next;
            res_key_reg     <= res_key_next;
            res_tag_reg     <= res_tag_next;
            res_payload_reg <= res_payload_next;
            occ_reg         <= fill_next;
            full_reg        <= next_full;
            empty_reg       <= next_empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;

    always_comb begin
        m_tdata                        = '0;
        m_tdata[SW-1:0]                = res_key_reg[KW-1 -: SW];
        m_tdata[P_SEQ +: QW]           = res_key_reg[QW-1:0];
        m_tdata[P_DIR +: DW]           = res_tag_reg[TW-1 -: DW];
        m_tdata[P_OWN +: OW]           = res_tag_reg[OW-1:0];
        m_tdata[P_PAY +: PAYLOAD_BITS] = res_payload_reg;
        m_tdata[P_OCC +: OCC_W]        = occ_reg;
        m_tdata[P_FUL]                 = full_reg;
        m_tdata[P_EMP]                 = empty_reg;
    end

endmodule

`default_nettype wire
